// File: rtl/text_terminal_cursor_engine_top_defines.svh
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine_top_defines
// assertion macros shared by the terminal cursor engine
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_TERMINAL_CURSOR_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TTCE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttce assertion failed");

// next-cycle implication, checked out of reset
`define TTCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttce assertion failed");

`endif

// File: rtl/ttce_pkg.sv
// ----------------------------------------------------------------------------
// ttce_pkg
// types and constants of the text terminal cursor engine
// ----------------------------------------------------------------------------
package ttce_pkg;

    localparam int CHAR_W  = 8;
    localparam int POS_W   = 8;
    localparam int COLOR_W = 32;
    localparam int INDEX_W = 8;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [INDEX_W-1:0] REG_COLUMNS = 8'd0;
    localparam logic [INDEX_W-1:0] REG_ROWS    = 8'd1;
    localparam logic [INDEX_W-1:0] REG_DEF_FG  = 8'd2;
    localparam logic [INDEX_W-1:0] REG_DEF_BG  = 8'd3;

    localparam logic [POS_W-1:0]   RST_COLUMNS = 8'd80;
    localparam logic [POS_W-1:0]   RST_ROWS    = 8'd25;
    localparam logic [COLOR_W-1:0] RST_DEF_FG  = 32'd15;
    localparam logic [COLOR_W-1:0] RST_DEF_BG  = 32'd0;

    localparam int RESULT_DEPTH = 4;

    typedef struct packed {
        logic               kind;
        logic [CHAR_W-1:0]  ch;
        logic [POS_W-1:0]   column;
        logic [POS_W-1:0]   row;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } run_t;

endpackage

// File: rtl/text_terminal_cursor_engine_top.sv
// Text terminal cursor engine. One character transfer is taken every clock cycle
// while in_ready is high; its cell write and/or clear-screen results appear on the
// output channel from the next cycle on, one result per cycle while out_ready is
// high, drained from a RESULT_DEPTH-entry result queue. in_ready falls while fewer
// than two queue entries are free (a printable character wrapping the last row gives
// a write plus a clear). The output rate sets the sustained throughput. Screen size
// and default colors use the cfg port; the user must write it only while the engine is idle (not enforced).
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine_top
// cursor tracking and cell/clear command generation for a text-mode screen
// ----------------------------------------------------------------------------
`include "text_terminal_cursor_engine_top_defines.svh"

module text_terminal_cursor_engine_top
#(
    parameter int RESULT_DEPTH = ttce_pkg::RESULT_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ttce_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [ttce_pkg::COLOR_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ttce_pkg::CHAR_W-1:0]   char_code,
    input  logic                          use_item_colors,
    input  logic [ttce_pkg::COLOR_W-1:0]  item_foreground,
    input  logic [ttce_pkg::COLOR_W-1:0]  item_background,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          command_kind,
    output logic [ttce_pkg::CHAR_W-1:0]   cell_char,
    output logic [ttce_pkg::POS_W-1:0]    cell_column,
    output logic [ttce_pkg::POS_W-1:0]    cell_row,
    output logic [ttce_pkg::COLOR_W-1:0]  out_foreground,
    output logic [ttce_pkg::COLOR_W-1:0]  out_background,
    output logic                          last_of_run
);

    localparam int CNT_W = $clog2(RESULT_DEPTH+1);

    logic [ttce_pkg::POS_W-1:0]   columns_reg;
    logic [ttce_pkg::POS_W-1:0]   rows_reg;
    logic [ttce_pkg::COLOR_W-1:0] def_fg_reg;
    logic [ttce_pkg::COLOR_W-1:0] def_bg_reg;
    logic                         cfg_xfer;
    logic                         in_xfer;
    logic                         out_xfer;
    ttce_pkg::run_t               run;
    ttce_pkg::result_t            head;
    logic [CNT_W-1:0]             q_count;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= ttce_pkg::RST_COLUMNS;
            rows_reg    <= ttce_pkg::RST_ROWS;
            def_fg_reg  <= ttce_pkg::RST_DEF_FG;
            def_bg_reg  <= ttce_pkg::RST_DEF_BG;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                ttce_pkg::REG_COLUMNS: columns_reg <= cfg_data[ttce_pkg::POS_W-1:0];
                ttce_pkg::REG_ROWS:    rows_reg    <= cfg_data[ttce_pkg::POS_W-1:0];
                ttce_pkg::REG_DEF_FG:  def_fg_reg  <= cfg_data;
                ttce_pkg::REG_DEF_BG:  def_bg_reg  <= cfg_data;
                default:               columns_reg <= columns_reg;
            endcase
        end
    end

    ttce_cursor u_cursor
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (in_xfer),
        .char_code          (char_code),
        .use_item_colors    (use_item_colors),
        .item_foreground    (item_foreground),
        .item_background    (item_background),
        .screen_columns     (columns_reg),
        .screen_rows        (rows_reg),
        .default_foreground (def_fg_reg),
        .default_background (def_bg_reg),
        .run                (run)
    );

    ttce_result_fifo #(.DEPTH(RESULT_DEPTH)) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (in_xfer),
        .run   (run),
        .pop   (out_xfer),
        .head  (head),
        .count (q_count)
    );

    assign in_ready       = q_count <= CNT_W'(RESULT_DEPTH - 2);
    assign out_valid      = q_count != '0;
    assign command_kind   = head.kind;
    assign cell_char      = head.ch;
    assign cell_column    = head.column;
    assign cell_row       = head.row;
    assign out_foreground = head.fg;
    assign out_background = head.bg;
    assign last_of_run    = head.last;

    // queue bookkeeping
    `TTCE_ASSERT_NOW(a_count_bound, 1'b1, q_count <= CNT_W'(RESULT_DEPTH))
    `TTCE_ASSERT_NOW(a_run_count, in_xfer, run.count <= 2'd2)
    `TTCE_ASSERT_NEXT(a_idle_item_holds, in_xfer && run.count == 2'd0 && !out_xfer, q_count == $past(q_count))
    `TTCE_ASSERT_NEXT(a_pop_only, out_xfer && !in_xfer, q_count == $past(q_count) - CNT_W'(1))

endmodule

// File: rtl/ttce_cursor.sv
// ----------------------------------------------------------------------------
// ttce_cursor
// cursor state and per-character decode into up to two results
// ----------------------------------------------------------------------------
module ttce_cursor
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [ttce_pkg::CHAR_W-1:0]   char_code,
    input  logic                          use_item_colors,
    input  logic [ttce_pkg::COLOR_W-1:0]  item_foreground,
    input  logic [ttce_pkg::COLOR_W-1:0]  item_background,
    input  logic [ttce_pkg::POS_W-1:0]    screen_columns,
    input  logic [ttce_pkg::POS_W-1:0]    screen_rows,
    input  logic [ttce_pkg::COLOR_W-1:0]  default_foreground,
    input  logic [ttce_pkg::COLOR_W-1:0]  default_background,
    output ttce_pkg::run_t                run
);

    logic [ttce_pkg::POS_W-1:0]   col_reg;
    logic [ttce_pkg::POS_W-1:0]   col_next;
    logic [ttce_pkg::POS_W-1:0]   row_reg;
    logic [ttce_pkg::POS_W-1:0]   row_next;
    logic [ttce_pkg::COLOR_W-1:0] fg;
    logic [ttce_pkg::COLOR_W-1:0] bg;
    logic [ttce_pkg::POS_W:0]     col_inc;
    logic [ttce_pkg::POS_W:0]     row_inc;
    logic                         col_wrap;
    logic                         row_wrap;
    logic [ttce_pkg::POS_W-1:0]   row_adv;
    logic [ttce_pkg::POS_W-1:0]   col_last;
    ttce_pkg::result_t            write_res;
    ttce_pkg::result_t            erase_res;
    ttce_pkg::result_t            clear_res;

    assign fg       = use_item_colors ? item_foreground : default_foreground;
    assign bg       = use_item_colors ? item_background : default_background;
    assign col_inc  = {1'b0, col_reg} + 9'd1;
    assign row_inc  = {1'b0, row_reg} + 9'd1;
    assign col_wrap = col_inc >= {1'b0, screen_columns};
    assign row_wrap = row_inc >= {1'b0, screen_rows};
    assign row_adv  = row_wrap ? '0 : row_inc[ttce_pkg::POS_W-1:0];
    assign col_last = (screen_columns == '0) ? '0 : screen_columns - 8'd1;

    assign write_res = '{kind: ttce_pkg::KIND_WRITE, ch: char_code, column: col_reg,
                         row: row_reg, fg: fg, bg: bg, last: 1'b1};
    assign erase_res = '{kind: ttce_pkg::KIND_WRITE, ch: ttce_pkg::CH_SPACE,
                         column: col_reg - 8'd1, row: row_reg, fg: fg, bg: bg,
                         last: 1'b1};
    assign clear_res = '{kind: ttce_pkg::KIND_CLEAR, ch: ttce_pkg::CH_SPACE,
                         column: '0, row: '0, fg: fg, bg: bg, last: 1'b1};

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        run.count = 2'd0;
        run.res0  = write_res;
        run.res1  = clear_res;
        case (char_code)
            ttce_pkg::CH_CR:
            begin
                col_next = '0;
            end
            ttce_pkg::CH_LF:
            begin
                col_next = '0;
                row_next = row_adv;
                if (row_wrap)
                begin
                    run.count = 2'd1;
                    run.res0  = clear_res;
                end
            end
            ttce_pkg::CH_FF:
            begin
                run.count = 2'd1;
                run.res0  = clear_res;
            end
            ttce_pkg::CH_TAB:
            begin
                col_next = col_reg;
            end
            ttce_pkg::CH_BS:
            begin
                if (col_reg != '0)
                begin
                    col_next  = col_reg - 8'd1;
                    run.count = 2'd1;
                    run.res0  = erase_res;
                end
                else if (row_reg != '0)
                begin
                    row_next = row_reg - 8'd1;
                    col_next = col_last;
                end
            end
            default:
            begin
                run.count = 2'd1;
                if (col_wrap)
                begin
                    col_next = '0;
                    row_next = row_adv;
                    if (row_wrap)
                    begin
                        run.count     = 2'd2;
                        run.res0.last = 1'b0;
                    end
                end
                else
                begin
                    col_next = col_inc[ttce_pkg::POS_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: rtl/ttce_result_fifo.sv
// ----------------------------------------------------------------------------
// ttce_result_fifo
// result queue taking up to two entries and giving one per cycle when popped
// ----------------------------------------------------------------------------
module ttce_result_fifo
#(
    parameter int DEPTH = ttce_pkg::RESULT_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  ttce_pkg::run_t                   run,
    input  logic                             pop,
    output ttce_pkg::result_t                head,
    output logic [$clog2(DEPTH+1)-1:0]       count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    ttce_pkg::result_t      mem [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       wr_ptr_plus1;
    logic [PTR_W-1:0]       wr_ptr_plus2;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       push_n;

    assign wr_ptr_plus1 = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_plus2 = (wr_ptr_plus1 == LAST_PTR) ? '0 : wr_ptr_plus1 + PTR_W'(1);
    assign push_n       = push ? CNT_W'(run.count) : '0;

    always_comb
    begin
        case (push_n)
            CNT_W'(1): wr_ptr_next = wr_ptr_plus1;
            CNT_W'(2): wr_ptr_next = wr_ptr_plus2;
            default:   wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + push_n - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != '0)
        begin
            mem[wr_ptr_reg] <= run.res0;
        end
        if (push_n == CNT_W'(2))
        begin
            mem[wr_ptr_plus1] <= run.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: test/ttce_command_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttce_command_checker
// follows the cursor from observed transfers and checks every emitted command
// ----------------------------------------------------------------------------
module ttce_command_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [ttce_pkg::INDEX_W-1:0] cfg_index,
    input  logic [ttce_pkg::COLOR_W-1:0] cfg_data,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [ttce_pkg::CHAR_W-1:0]  char_code,
    input  logic                         use_item_colors,
    input  logic [ttce_pkg::COLOR_W-1:0] item_foreground,
    input  logic [ttce_pkg::COLOR_W-1:0] item_background,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         command_kind,
    input  logic [ttce_pkg::CHAR_W-1:0]  cell_char,
    input  logic [ttce_pkg::POS_W-1:0]   cell_column,
    input  logic [ttce_pkg::POS_W-1:0]   cell_row,
    input  logic [ttce_pkg::COLOR_W-1:0] out_foreground,
    input  logic [ttce_pkg::COLOR_W-1:0] out_background,
    input  logic                         last_of_run,
    output int                           mismatch_count,
    output int                           commands_due
);

    logic [ttce_pkg::POS_W-1:0]   screen_cols;
    logic [ttce_pkg::POS_W-1:0]   screen_rows;
    logic [ttce_pkg::COLOR_W-1:0] base_fg;
    logic [ttce_pkg::COLOR_W-1:0] base_bg;
    logic [ttce_pkg::POS_W-1:0]   cur_col;
    logic [ttce_pkg::POS_W-1:0]   cur_row;
    ttce_pkg::result_t            awaited_commands[$];

    function automatic ttce_pkg::result_t make_command(logic kind,
            logic [ttce_pkg::CHAR_W-1:0] ch,
            logic [ttce_pkg::POS_W-1:0] col, logic [ttce_pkg::POS_W-1:0] row,
            logic [ttce_pkg::COLOR_W-1:0] fg, logic [ttce_pkg::COLOR_W-1:0] bg);
        ttce_pkg::result_t cmd;
        cmd.kind   = kind;
        cmd.ch     = ch;
        cmd.column = col;
        cmd.row    = row;
        cmd.fg     = fg;
        cmd.bg     = bg;
        cmd.last   = 1'b0;
        return cmd;
    endfunction

    // moves to the next row, returns 1 when the screen has to be cleared
    function automatic logic advance_row();
        if (int'(cur_row) + 1 >= int'(screen_rows))
        begin
            cur_row = '0;
            return 1'b1;
        end
        cur_row = cur_row + 1'b1;
        return 1'b0;
    endfunction

    function automatic void predict_commands(logic [ttce_pkg::CHAR_W-1:0] code, logic own,
            logic [ttce_pkg::COLOR_W-1:0] ifg, logic [ttce_pkg::COLOR_W-1:0] ibg);
        logic [ttce_pkg::COLOR_W-1:0] fg;
        logic [ttce_pkg::COLOR_W-1:0] bg;
        ttce_pkg::result_t            run_cmds[2];
        int                           n;
        fg = own ? ifg : base_fg;
        bg = own ? ibg : base_bg;
        n  = 0;
        case (code)
            ttce_pkg::CH_CR:
                cur_col = '0;
            ttce_pkg::CH_LF:
            begin
                cur_col = '0;
                if (advance_row())
                begin
                    run_cmds[n] = make_command(ttce_pkg::KIND_CLEAR, ttce_pkg::CH_SPACE,
                                               '0, '0, fg, bg);
                    n++;
                end
            end
            ttce_pkg::CH_FF:
            begin
                run_cmds[n] = make_command(ttce_pkg::KIND_CLEAR, ttce_pkg::CH_SPACE,
                                           '0, '0, fg, bg);
                n++;
            end
            ttce_pkg::CH_TAB:
                ;
            ttce_pkg::CH_BS:
            begin
                if (cur_col != '0)
                begin
                    cur_col = cur_col - 1'b1;
                    run_cmds[n] = make_command(ttce_pkg::KIND_WRITE, ttce_pkg::CH_SPACE,
                                               cur_col, cur_row, fg, bg);
                    n++;
                end
                else if (cur_row != '0)
                begin
                    cur_row = cur_row - 1'b1;
                    cur_col = (screen_cols == '0) ? '0 : screen_cols - 1'b1;
                end
            end
            default:
            begin
                run_cmds[n] = make_command(ttce_pkg::KIND_WRITE, code, cur_col, cur_row,
                                           fg, bg);
                n++;
                if (int'(cur_col) + 1 >= int'(screen_cols))
                begin
                    cur_col = '0;
                    if (advance_row())
                    begin
                        run_cmds[n] = make_command(ttce_pkg::KIND_CLEAR, ttce_pkg::CH_SPACE,
                                                   '0, '0, fg, bg);
                        n++;
                    end
                end
                else
                    cur_col = cur_col + 1'b1;
            end
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                run_cmds[i].last = 1'b1;
            awaited_commands.push_back(run_cmds[i]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        ttce_pkg::result_t seen;
        ttce_pkg::result_t want;
        if (!rst_n)
        begin
            screen_cols = ttce_pkg::RST_COLUMNS;
            screen_rows = ttce_pkg::RST_ROWS;
            base_fg     = ttce_pkg::RST_DEF_FG;
            base_bg     = ttce_pkg::RST_DEF_BG;
            cur_col     = '0;
            cur_row     = '0;
            awaited_commands.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen.kind   = command_kind;
                seen.ch     = cell_char;
                seen.column = cell_column;
                seen.row    = cell_row;
                seen.fg     = out_foreground;
                seen.bg     = out_background;
                seen.last   = last_of_run;
                if (awaited_commands.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected command kind=%0d char=%02h col=%0d row=%0d",
                                 $realtime, seen.kind, seen.ch, seen.column, seen.row);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_commands.pop_front();
                    if (seen.kind !== want.kind || seen.ch !== want.ch ||
                        seen.column !== want.column || seen.row !== want.row ||
                        seen.fg !== want.fg || seen.bg !== want.bg ||
                        seen.last !== want.last)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("%0t: command mismatch", $realtime);
                            $display("  expected kind=%0d char=%02h col=%0d row=%0d fg=%08h bg=%08h last=%0d",
                                     want.kind, want.ch, want.column, want.row,
                                     want.fg, want.bg, want.last);
                            $display("  actual   kind=%0d char=%02h col=%0d row=%0d fg=%08h bg=%08h last=%0d",
                                     seen.kind, seen.ch, seen.column, seen.row,
                                     seen.fg, seen.bg, seen.last);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ttce_pkg::REG_COLUMNS: screen_cols = cfg_data[ttce_pkg::POS_W-1:0];
                    ttce_pkg::REG_ROWS:    screen_rows = cfg_data[ttce_pkg::POS_W-1:0];
                    ttce_pkg::REG_DEF_FG:  base_fg     = cfg_data;
                    ttce_pkg::REG_DEF_BG:  base_bg     = cfg_data;
                    default:               ;
                endcase
            end
            if (in_valid && in_ready)
                predict_commands(char_code, use_item_colors, item_foreground, item_background);
        end
        commands_due = awaited_commands.size();
    end

endmodule

// File: test/tb_text_terminal_cursor_engine_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_terminal_cursor_engine_top
// character stream stimulus across screen sizes, with random stalls on both
// channels; the command checker predicts and compares every cell write and clear
// ----------------------------------------------------------------------------
module tb_text_terminal_cursor_engine_top;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [ttce_pkg::INDEX_W-1:0] cfg_index;
    logic [ttce_pkg::COLOR_W-1:0] cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    logic [ttce_pkg::CHAR_W-1:0]  char_code;
    logic                         use_item_colors;
    logic [ttce_pkg::COLOR_W-1:0] item_foreground;
    logic [ttce_pkg::COLOR_W-1:0] item_background;
    logic                         out_valid;
    logic                         out_ready;
    logic                         command_kind;
    logic [ttce_pkg::CHAR_W-1:0]  cell_char;
    logic [ttce_pkg::POS_W-1:0]   cell_column;
    logic [ttce_pkg::POS_W-1:0]   cell_row;
    logic [ttce_pkg::COLOR_W-1:0] out_foreground;
    logic [ttce_pkg::COLOR_W-1:0] out_background;
    logic                         last_of_run;
    int                           mismatch_count;
    int                           commands_due;
    bit                           steady_stretch;

    text_terminal_cursor_engine_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .char_code       (char_code),
        .use_item_colors (use_item_colors),
        .item_foreground (item_foreground),
        .item_background (item_background),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .command_kind    (command_kind),
        .cell_char       (cell_char),
        .cell_column     (cell_column),
        .cell_row        (cell_row),
        .out_foreground  (out_foreground),
        .out_background  (out_background),
        .last_of_run     (last_of_run)
    );

    ttce_command_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .char_code       (char_code),
        .use_item_colors (use_item_colors),
        .item_foreground (item_foreground),
        .item_background (item_background),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .command_kind    (command_kind),
        .cell_char       (cell_char),
        .cell_column     (cell_column),
        .cell_row        (cell_row),
        .out_foreground  (out_foreground),
        .out_background  (out_background),
        .last_of_run     (last_of_run),
        .mismatch_count  (mismatch_count),
        .commands_due    (commands_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_text_terminal_cursor_engine_top: FAIL");
        $finish;
    end

    // command receiver with random stalls and two long hold-offs
    initial
    begin : receiver
        int stall;
        int taken;
        out_ready = 1'b0;
        taken     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (taken == 300 || taken == 900)
                stall = 160;
            else
                stall = steady_stretch ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    function automatic logic [ttce_pkg::COLOR_W-1:0] random_color();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ttce_pkg::CHAR_W-1:0] random_char();
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0:       return ttce_pkg::CH_BS;
            1:       return ttce_pkg::CH_TAB;
            2:       return ttce_pkg::CH_LF;
            3:       return ttce_pkg::CH_FF;
            default: return ttce_pkg::CH_CR;
        endcase
    endfunction

    task automatic send_char(input logic [ttce_pkg::CHAR_W-1:0] code, input logic own,
                             input logic [ttce_pkg::COLOR_W-1:0] fg,
                             input logic [ttce_pkg::COLOR_W-1:0] bg);
        int gap;
        gap = steady_stretch ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        char_code       <= code;
        use_item_colors <= own;
        item_foreground <= fg;
        item_background <= bg;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_random_char();
        send_char(random_char(), 1'($urandom_range(0, 1)), random_color(), random_color());
    endtask

    // drain the engine, then write all four registers
    task automatic set_screen(input logic [ttce_pkg::POS_W-1:0] cols,
                              input logic [ttce_pkg::POS_W-1:0] rows,
                              input logic [ttce_pkg::COLOR_W-1:0] fg,
                              input logic [ttce_pkg::COLOR_W-1:0] bg);
        logic [ttce_pkg::INDEX_W-1:0] reg_ids[4];
        logic [ttce_pkg::COLOR_W-1:0] reg_vals[4];
        reg_ids[0]  = ttce_pkg::REG_COLUMNS;
        reg_ids[1]  = ttce_pkg::REG_ROWS;
        reg_ids[2]  = ttce_pkg::REG_DEF_FG;
        reg_ids[3]  = ttce_pkg::REG_DEF_BG;
        reg_vals[0] = {{(ttce_pkg::COLOR_W-ttce_pkg::POS_W){1'b0}}, cols};
        reg_vals[1] = {{(ttce_pkg::COLOR_W-ttce_pkg::POS_W){1'b0}}, rows};
        reg_vals[2] = fg;
        reg_vals[3] = bg;
        in_valid <= 1'b0;
        wait (commands_due == 0);
        repeat (8) @(negedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_ids[i];
            cfg_data  <= reg_vals[i];
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [ttce_pkg::POS_W-1:0] cols;
        logic [ttce_pkg::POS_W-1:0] rows;
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        char_code       = '0;
        use_item_colors = 1'b0;
        item_foreground = '0;
        item_background = '0;
        steady_stretch  = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset screen size and colors
        send_char(8'h41, 1'b0, '0, '0);
        send_char(8'hFF, 1'b1, '1, '1);
        send_char(8'h00, 1'b1, '0, '0);
        send_char(ttce_pkg::CH_TAB, 1'b0, '0, '0);
        send_char(ttce_pkg::CH_BS, 1'b0, '0, '0);
        send_char(ttce_pkg::CH_CR, 1'b0, '0, '0);
        send_char(ttce_pkg::CH_BS, 1'b0, '0, '0);
        send_char(ttce_pkg::CH_LF, 1'b0, '0, '0);
        send_char(ttce_pkg::CH_BS, 1'b0, '0, '0);
        send_char(8'h5A, 1'b1, $urandom, $urandom);
        send_char(ttce_pkg::CH_FF, 1'b1, $urandom, $urandom);

        // tiny screen: line wrap and clear on the last row
        set_screen(8'd3, 8'd2, '1, '0);
        repeat (6) send_char(8'($urandom_range(33, 126)), 1'b0, '0, '0);
        send_char(ttce_pkg::CH_LF, 1'b1, $urandom, $urandom);

        // largest screen, then shrink under the cursor
        set_screen(8'd255, 8'd255, '0, '1);
        repeat (3) send_char(ttce_pkg::CH_LF, 1'b0, '0, '0);
        repeat (6) send_char(8'($urandom_range(33, 126)), 1'b0, '0, '0);
        set_screen(8'd4, 8'd3, $urandom, $urandom);
        send_char(8'h7E, 1'b0, '0, '0);

        // zero columns and rows
        set_screen(8'd0, 8'd0, $urandom, $urandom);
        send_char(8'h31, 1'b0, '0, '0);
        send_char(ttce_pkg::CH_LF, 1'b0, '0, '0);
        set_screen(8'd0, 8'd5, $urandom, $urandom);
        send_char(8'h32, 1'b0, '0, '0);
        send_char(ttce_pkg::CH_BS, 1'b0, '0, '0);

        for (int phase = 0; phase < 11; phase++)
        begin
            case (phase % 5)
                0:
                begin
                    cols = 8'($urandom_range(1, 6));
                    rows = 8'($urandom_range(1, 4));
                end
                1:
                begin
                    cols = 8'($urandom_range(1, 255));
                    rows = 8'($urandom_range(1, 255));
                end
                2:
                begin
                    cols = 8'd1;
                    rows = 8'd1;
                end
                3:
                begin
                    cols = 8'd255;
                    rows = 8'd255;
                end
                default:
                begin
                    cols = 8'($urandom_range(0, 3));
                    rows = 8'($urandom_range(0, 3));
                end
            endcase
            set_screen(cols, rows, random_color(), random_color());
            for (int k = 0; k < 150; k++)
            begin
                steady_stretch = (k % 60) >= 45;
                send_random_char();
            end
            steady_stretch = 1'b0;
        end

        in_valid <= 1'b0;
        wait (commands_due == 0);
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && commands_due == 0)
            $display("tb_text_terminal_cursor_engine_top: PASS");
        else
            $display("tb_text_terminal_cursor_engine_top: FAIL");
        $finish;
    end

endmodule
